// ===== sv/trqs_pkg.sv =====
// Shared constants, codes and control structs of the thread ready-queue scheduler.
package trqs_pkg;

    localparam int THREAD_SLOTS = 32;
    localparam int ID_W         = $clog2(THREAD_SLOTS);
    localparam int CNT_W        = $clog2(THREAD_SLOTS + 1);
    localparam int CMD_W        = 3;
    localparam int TARGET_W     = 8;
    localparam int STATUS_W     = 3;
    localparam int RESULT_W     = 7;

    localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_EXIT     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_KILL     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_YIELD    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_YIELD_TO = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE      = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD          = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_READY    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_INVALID      = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_NONE_RUNNING = 3'd5;
    localparam logic [STATUS_W-1:0] STATUS_ALL_EXITED   = 3'd6;

    localparam int LOP_W = 3;
    localparam logic [LOP_W-1:0] LOP_APPEND        = 3'd0;
    localparam logic [LOP_W-1:0] LOP_POP           = 3'd1;
    localparam logic [LOP_W-1:0] LOP_UNLINK        = 3'd2;
    localparam logic [LOP_W-1:0] LOP_POP_APPEND    = 3'd3;
    localparam logic [LOP_W-1:0] LOP_UNLINK_APPEND = 3'd4;

    typedef struct packed {
        logic             start;
        logic [LOP_W-1:0] op;
        logic [ID_W-1:0]  id;
        logic [ID_W-1:0]  app_id;
    } trqs_list_req_t;

    typedef struct packed {
        logic            done;
        logic            ok;
        logic [ID_W-1:0] popped;
        logic            empty;
    } trqs_list_rsp_t;

endpackage

// ===== sv/trqs_if.sv =====
// Command and response channel interfaces of the thread ready-queue scheduler.
interface trqs_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [trqs_pkg::CMD_W-1:0]     command;
    logic [trqs_pkg::TARGET_W-1:0]  target_thread;

    modport source (output valid, output command, output target_thread, input ready);
    modport sink   (input valid, input command, input target_thread, output ready);
endinterface

interface trqs_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [trqs_pkg::STATUS_W-1:0]  status;
    logic [trqs_pkg::RESULT_W-1:0]  result_thread;
    logic [trqs_pkg::RESULT_W-1:0]  running_thread;
    logic                           running_valid;

    modport source (output valid, output status, output result_thread,
                    output running_thread, output running_valid, input ready);
    modport sink   (input valid, input status, input result_thread,
                    input running_thread, input running_valid, output ready);
endinterface

// ===== sv/trqs_list.sv =====
// Ready list engine: link memory, head, tail and the list operations.
module trqs_list (
    input  logic                     clk,
    input  logic                     rst_n,
    input  trqs_pkg::trqs_list_req_t req,
    output trqs_pkg::trqs_list_rsp_t rsp
);

    localparam logic [2:0] L_IDLE        = 3'd0;
    localparam logic [2:0] L_POP_WAIT    = 3'd1;
    localparam logic [2:0] L_WALK_WAIT   = 3'd2;
    localparam logic [2:0] L_SPLICE_WAIT = 3'd3;
    localparam logic [2:0] L_APPEND      = 3'd4;
    localparam logic [2:0] L_FINISH      = 3'd5;

    logic [trqs_pkg::ID_W-1:0] link_mem [trqs_pkg::THREAD_SLOTS];
    logic [trqs_pkg::ID_W-1:0] rdata_reg;

    logic [2:0]                      state_reg, state_next;
    logic [trqs_pkg::LOP_W-1:0]      op_reg, op_next;
    logic [trqs_pkg::ID_W-1:0]       id_reg, id_next;
    logic [trqs_pkg::ID_W-1:0]       app_reg, app_next;
    logic [trqs_pkg::ID_W-1:0]       head_reg, head_next;
    logic [trqs_pkg::ID_W-1:0]       tail_reg, tail_next;
    logic                            empty_reg, empty_next;
    logic [trqs_pkg::ID_W-1:0]       prev_reg, prev_next;
    logic [trqs_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                            ok_reg, ok_next;
    logic [trqs_pkg::ID_W-1:0]       popped_reg, popped_next;

    logic                      rd_en;
    logic [trqs_pkg::ID_W-1:0] rd_addr;
    logic                      wr_en;
    logic [trqs_pkg::ID_W-1:0] wr_addr;
    logic [trqs_pkg::ID_W-1:0] wr_data;
    logic                      append_after;
    logic                      do_pop;

    assign append_after = (op_next == trqs_pkg::LOP_POP_APPEND) ||
                          (op_next == trqs_pkg::LOP_UNLINK_APPEND);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        app_next    = app_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        prev_next   = prev_reg;
        cnt_next    = cnt_reg;
        ok_next     = ok_reg;
        popped_next = popped_reg;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        wr_en       = 1'b0;
        wr_addr     = tail_reg;
        wr_data     = id_reg;
        do_pop      = 1'b0;

        unique case (state_reg)
            L_IDLE:
            begin
                if (req.start)
                begin
                    op_next     = req.op;
                    id_next     = req.id;
                    app_next    = req.app_id;
                    ok_next     = 1'b1;
                    popped_next = head_reg;
                    priority if (req.op == trqs_pkg::LOP_APPEND)
                    begin
                        state_next = L_APPEND;
                    end
                    else if (req.op == trqs_pkg::LOP_POP || req.op == trqs_pkg::LOP_POP_APPEND)
                    begin
                        do_pop = 1'b1;
                    end
                    else if (empty_reg)
                    begin
                        ok_next    = 1'b0;
                        state_next = L_FINISH;
                    end
                    else if (head_reg == req.id)
                    begin
                        do_pop = 1'b1;
                    end
                    else if (head_reg == tail_reg)
                    begin
                        ok_next    = 1'b0;
                        state_next = L_FINISH;
                    end
                    else
                    begin
                        prev_next  = head_reg;
                        rd_en      = 1'b1;
                        rd_addr    = head_reg;
                        cnt_next   = trqs_pkg::CNT_W'(1);
                        state_next = L_WALK_WAIT;
                    end

                    if (do_pop)
                    begin
                        if (head_reg == tail_reg)
                        begin
                            empty_next = 1'b1;
                            state_next = append_after ? L_APPEND : L_FINISH;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = L_POP_WAIT;
                        end
                    end
                end
            end

            L_POP_WAIT:
            begin
                head_next  = rdata_reg;
                state_next = append_after ? L_APPEND : L_FINISH;
            end

            L_WALK_WAIT:
            begin
                if (rdata_reg == id_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = rdata_reg;
                    state_next = L_SPLICE_WAIT;
                end
                else
                begin
                    prev_next = rdata_reg;
                    if (cnt_reg == trqs_pkg::CNT_W'(trqs_pkg::THREAD_SLOTS) ||
                        rdata_reg == tail_reg)
                    begin
                        ok_next    = 1'b0;
                        state_next = L_FINISH;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = rdata_reg;
                        cnt_next = cnt_reg + trqs_pkg::CNT_W'(1);
                    end
                end
            end

            L_SPLICE_WAIT:
            begin
                wr_en   = 1'b1;
                wr_addr = prev_reg;
                wr_data = rdata_reg;
                if (tail_reg == id_reg)
                begin
                    tail_next = prev_reg;
                end
                state_next = append_after ? L_APPEND : L_FINISH;
            end

            L_APPEND:
            begin
                if (empty_reg)
                begin
                    head_next  = app_reg;
                    empty_next = 1'b0;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = tail_reg;
                    wr_data = app_reg;
                end
                tail_next  = app_reg;
                state_next = L_FINISH;
            end

            L_FINISH:
            begin
                state_next = L_IDLE;
            end

            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= link_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        app_reg    <= app_next;
        prev_reg   <= prev_next;
        cnt_reg    <= cnt_next;
        ok_reg     <= ok_next;
        popped_reg <= popped_next;
    end

    assign rsp.done   = (state_reg == L_FINISH);
    assign rsp.ok     = ok_reg;
    assign rsp.popped = popped_reg;
    assign rsp.empty  = empty_reg;

endmodule

// ===== sv/thread_ready_queue_scheduler.sv =====
// Top level of the thread ready-queue scheduler: slot table, running thread, command sequencer.
//
// Commands arrive on the cmd channel (command, target_thread) and each produces exactly
// one transfer on the rsp channel (status, result_thread, running_thread, running_valid).
// One command is worked on at a time; cmd.ready is high only while the sequencer is idle.
// Work done between command transfer and response:
//   query and rejected commands   no ready list operation
//   exit                          at most one link memory read, for the new list head
//   yield                         head read, then the append
//   create                        lowest free slot scanned one per cycle, then the append
//   kill, yield_to                ready list walked one link memory read per cycle, plus the
//                                 splice and, for yield_to, the append
// The ready list lives in a single-port-read link memory with a registered read port;
// that walk and the free-slot scan set the worst case.
// The response sits in an output register: a new command is taken while it still waits,
// and a finished command holds in the sequencer until the register is free when rsp stalls.
// After reset slot zero is running, every other slot is free and the ready list is empty;
// no clearing pass is needed, and a command may follow directly after reset.
module thread_ready_queue_scheduler (
    input  logic            clk,
    input  logic            rst_n,
    trqs_cmd_if.sink        cmd,
    trqs_rsp_if.source      rsp
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_LIST   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]                          state_reg, state_next;
    logic [trqs_pkg::CMD_W-1:0]          cmd_reg, cmd_next;
    logic [trqs_pkg::ID_W-1:0]           tgt_reg, tgt_next;
    logic                                tgt_ok_reg, tgt_ok_next;
    logic [trqs_pkg::THREAD_SLOTS-1:0]   used_reg, used_next;
    logic [trqs_pkg::ID_W-1:0]           running_id_reg, running_id_next;
    logic                                running_flag_reg, running_flag_next;
    logic [trqs_pkg::ID_W-1:0]           scan_reg, scan_next;
    logic [trqs_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic [trqs_pkg::ID_W-1:0]           result_reg, result_next;

    logic                                rsp_valid_reg, rsp_valid_next;
    logic [trqs_pkg::STATUS_W-1:0]       rsp_status_reg, rsp_status_next;
    logic [trqs_pkg::RESULT_W-1:0]       rsp_result_reg, rsp_result_next;
    logic [trqs_pkg::RESULT_W-1:0]       rsp_running_reg, rsp_running_next;
    logic                                rsp_run_valid_reg, rsp_run_valid_next;

    trqs_pkg::trqs_list_req_t            list_req;
    trqs_pkg::trqs_list_rsp_t            list_rsp;

    logic                                tgt_running;
    logic                                tgt_used;
    logic                                rsp_free;

    trqs_list u_list (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (list_req),
        .rsp   (list_rsp)
    );

    assign cmd.ready   = (state_reg == S_IDLE);
    assign tgt_running = running_flag_reg && (running_id_reg == tgt_reg);
    assign tgt_used    = used_reg[tgt_reg];
    assign rsp_free    = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        state_next         = state_reg;
        cmd_next           = cmd_reg;
        tgt_next           = tgt_reg;
        tgt_ok_next        = tgt_ok_reg;
        used_next          = used_reg;
        running_id_next    = running_id_reg;
        running_flag_next  = running_flag_reg;
        scan_next          = scan_reg;
        status_next        = status_reg;
        result_next        = result_reg;
        rsp_valid_next     = rsp_valid_reg && !rsp.ready;
        rsp_status_next    = rsp_status_reg;
        rsp_result_next    = rsp_result_reg;
        rsp_running_next   = rsp_running_reg;
        rsp_run_valid_next = rsp_run_valid_reg;
        list_req           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next    = cmd.command;
                    tgt_next    = cmd.target_thread[trqs_pkg::ID_W-1:0];
                    tgt_ok_next = cmd.target_thread <
                                  trqs_pkg::TARGET_W'(trqs_pkg::THREAD_SLOTS);
                    status_next = trqs_pkg::STATUS_OK;
                    result_next = '0;
                    scan_next   = '0;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_DONE;
                unique case (cmd_reg)
                    trqs_pkg::CMD_CREATE:
                    begin
                        state_next = S_SCAN;
                    end

                    trqs_pkg::CMD_EXIT:
                    begin
                        if (running_flag_reg)
                        begin
                            used_next[running_id_reg] = 1'b0;
                            running_flag_next         = 1'b0;
                        end
                        if (list_rsp.empty)
                        begin
                            status_next = running_flag_reg ? trqs_pkg::STATUS_ALL_EXITED
                                                           : trqs_pkg::STATUS_NONE_RUNNING;
                        end
                        else
                        begin
                            list_req.start = 1'b1;
                            list_req.op    = trqs_pkg::LOP_POP;
                            state_next     = S_LIST;
                        end
                    end

                    trqs_pkg::CMD_KILL:
                    begin
                        priority if (!tgt_ok_reg)
                        begin
                            status_next = trqs_pkg::STATUS_INVALID;
                        end
                        else if (tgt_running)
                        begin
                            status_next = trqs_pkg::STATUS_BAD;
                        end
                        else if (!tgt_used)
                        begin
                            status_next = trqs_pkg::STATUS_NOT_READY;
                        end
                        else
                        begin
                            list_req.start = 1'b1;
                            list_req.op    = trqs_pkg::LOP_UNLINK;
                            list_req.id    = tgt_reg;
                            state_next     = S_LIST;
                        end
                    end

                    trqs_pkg::CMD_YIELD:
                    begin
                        priority if (!running_flag_reg)
                        begin
                            status_next = trqs_pkg::STATUS_NONE_RUNNING;
                        end
                        else if (list_rsp.empty)
                        begin
                            result_next = running_id_reg;
                        end
                        else
                        begin
                            list_req.start  = 1'b1;
                            list_req.op     = trqs_pkg::LOP_POP_APPEND;
                            list_req.app_id = running_id_reg;
                            state_next      = S_LIST;
                        end
                    end

                    trqs_pkg::CMD_YIELD_TO:
                    begin
                        priority if (!tgt_ok_reg)
                        begin
                            status_next = trqs_pkg::STATUS_INVALID;
                        end
                        else if (tgt_running)
                        begin
                            result_next = tgt_reg;
                        end
                        else if (!tgt_used)
                        begin
                            status_next = trqs_pkg::STATUS_BAD;
                        end
                        else if (!running_flag_reg)
                        begin
                            status_next = trqs_pkg::STATUS_NONE_RUNNING;
                        end
                        else
                        begin
                            // unlink the target, then queue the running thread
                            list_req.start  = 1'b1;
                            list_req.op     = trqs_pkg::LOP_UNLINK_APPEND;
                            list_req.id     = tgt_reg;
                            list_req.app_id = running_id_reg;
                            state_next      = S_LIST;
                        end
                    end

                    default:
                    begin
                        if (running_flag_reg)
                        begin
                            result_next = running_id_reg;
                        end
                        else
                        begin
                            status_next = trqs_pkg::STATUS_NONE_RUNNING;
                        end
                    end
                endcase
            end

            S_SCAN:
            begin
                priority if (!used_reg[scan_reg])
                begin
                    used_next[scan_reg] = 1'b1;
                    result_next         = scan_reg;
                    list_req.start      = 1'b1;
                    list_req.op         = trqs_pkg::LOP_APPEND;
                    list_req.app_id     = scan_reg;
                    state_next          = S_LIST;
                end
                else if (scan_reg == trqs_pkg::ID_W'(trqs_pkg::THREAD_SLOTS - 1))
                begin
                    status_next = trqs_pkg::STATUS_NO_FREE;
                    state_next  = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + trqs_pkg::ID_W'(1);
                end
            end

            S_LIST:
            begin
                if (list_rsp.done)
                begin
                    state_next = S_DONE;
                    unique case (cmd_reg)
                        trqs_pkg::CMD_EXIT, trqs_pkg::CMD_YIELD:
                        begin
                            running_id_next   = list_rsp.popped;
                            running_flag_next = 1'b1;
                            result_next       = list_rsp.popped;
                        end

                        trqs_pkg::CMD_KILL:
                        begin
                            if (list_rsp.ok)
                            begin
                                used_next[tgt_reg] = 1'b0;
                                result_next        = tgt_reg;
                            end
                            else
                            begin
                                status_next = trqs_pkg::STATUS_NOT_READY;
                            end
                        end

                        trqs_pkg::CMD_YIELD_TO:
                        begin
                            if (list_rsp.ok)
                            begin
                                running_id_next   = tgt_reg;
                                running_flag_next = 1'b1;
                                result_next       = tgt_reg;
                            end
                            else
                            begin
                                status_next = trqs_pkg::STATUS_NOT_READY;
                            end
                        end

                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_status_next    = status_reg;
                    rsp_result_next    = (status_reg == trqs_pkg::STATUS_OK)
                                         ? trqs_pkg::RESULT_W'(result_reg) : '0;
                    rsp_running_next   = running_flag_reg
                                         ? trqs_pkg::RESULT_W'(running_id_reg) : '0;
                    rsp_run_valid_next = running_flag_reg;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            used_reg         <= trqs_pkg::THREAD_SLOTS'(1);
            running_id_reg   <= '0;
            running_flag_reg <= 1'b1;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            used_reg         <= used_next;
            running_id_reg   <= running_id_next;
            running_flag_reg <= running_flag_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg           <= cmd_next;
        tgt_reg           <= tgt_next;
        tgt_ok_reg        <= tgt_ok_next;
        scan_reg          <= scan_next;
        status_reg        <= status_next;
        result_reg        <= result_next;
        rsp_status_reg    <= rsp_status_next;
        rsp_result_reg    <= rsp_result_next;
        rsp_running_reg   <= rsp_running_next;
        rsp_run_valid_reg <= rsp_run_valid_next;
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_status_reg;
    assign rsp.result_thread  = rsp_result_reg;
    assign rsp.running_thread = rsp_running_reg;
    assign rsp.running_valid  = rsp_run_valid_reg;

endmodule

// ===== sv/trqs_checker.sv =====
// Port-level assertions of the thread ready-queue scheduler and their bind.
module trqs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [trqs_pkg::STATUS_W-1:0]  rsp_status,
    input logic [trqs_pkg::RESULT_W-1:0]  rsp_result_thread,
    input logic [trqs_pkg::RESULT_W-1:0]  rsp_running_thread,
    input logic                           rsp_running_valid
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
        $stable(rsp_result_thread) && $stable(rsp_running_thread) &&
        $stable(rsp_running_valid))
        else $error("response changed while stalled");

    a_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != trqs_pkg::STATUS_OK |-> rsp_result_thread == '0)
        else $error("result thread set on a failed command");

    a_running_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_running_valid |-> rsp_running_thread == '0)
        else $error("running thread set while nothing runs");

    a_all_exited: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == trqs_pkg::STATUS_ALL_EXITED |-> !rsp_running_valid)
        else $error("thread running after all exited");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status <= trqs_pkg::STATUS_ALL_EXITED)
        else $error("undefined status code");

endmodule

bind thread_ready_queue_scheduler trqs_checker u_trqs_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_result_thread  (rsp.result_thread),
    .rsp_running_thread (rsp.running_thread),
    .rsp_running_valid  (rsp.running_valid)
);

// ===== tb/sv/tb_thread_ready_queue_scheduler.sv =====
// Self-checking testbench for the thread ready-queue scheduler: stimulus, prediction, checking.
typedef enum logic [1:0] {SLOT_FREE, SLOT_RUNNING, SLOT_READY} slot_state_t;

typedef struct packed {
    logic [trqs_pkg::STATUS_W-1:0] status;
    logic [trqs_pkg::RESULT_W-1:0] result_thread;
    logic [trqs_pkg::RESULT_W-1:0] running_thread;
    logic                          running_valid;
} sched_reply_t;

class sched_scoreboard;
    slot_state_t  slots[trqs_pkg::THREAD_SLOTS];
    int unsigned  ready_list[$];
    int unsigned  run_id;
    bit           run_flag;
    sched_reply_t replies_due[$];
    int unsigned  failures;

    function new();
        int i;
        for (i = 0; i < trqs_pkg::THREAD_SLOTS; i++)
            slots[i] = SLOT_FREE;
        slots[0]  = SLOT_RUNNING;
        run_id    = 0;
        run_flag  = 1'b1;
        failures  = 0;
    endfunction

    function int locate(int unsigned id);
        int i;
        for (i = 0; i < ready_list.size(); i++)
            if (ready_list[i] == id)
                return i;
        return -1;
    endfunction

    function void dispatch(int unsigned id);
        slots[id] = SLOT_RUNNING;
        run_id    = id;
        run_flag  = 1'b1;
    endfunction

    function void note_command(logic [trqs_pkg::CMD_W-1:0] code,
                               logic [trqs_pkg::TARGET_W-1:0] target);
        logic [trqs_pkg::STATUS_W-1:0] st;
        int unsigned                   res;
        int unsigned                   head;
        int unsigned                   tgt;
        bit                            tgt_ok;
        int                            idx;
        int                            i;
        sched_reply_t                  r;
        st     = trqs_pkg::STATUS_OK;
        res    = 0;
        tgt_ok = target < trqs_pkg::THREAD_SLOTS;
        tgt    = tgt_ok ? target : 0;
        case (code)
            trqs_pkg::CMD_CREATE:
            begin
                st = trqs_pkg::STATUS_NO_FREE;
                for (i = 0; i < trqs_pkg::THREAD_SLOTS; i++)
                begin
                    if (slots[i] == SLOT_FREE)
                    begin
                        slots[i] = SLOT_READY;
                        ready_list.push_back(i);
                        st  = trqs_pkg::STATUS_OK;
                        res = i;
                        break;
                    end
                end
            end
            trqs_pkg::CMD_EXIT:
            begin
                if (run_flag)
                begin
                    slots[run_id] = SLOT_FREE;
                    run_flag = 1'b0;
                    if (ready_list.size() == 0)
                        st = trqs_pkg::STATUS_ALL_EXITED;
                end
                else if (ready_list.size() == 0)
                    st = trqs_pkg::STATUS_NONE_RUNNING;
                if (st == trqs_pkg::STATUS_OK)
                begin
                    head = ready_list.pop_front();
                    dispatch(head);
                    res = head;
                end
            end
            trqs_pkg::CMD_KILL:
            begin
                if (!tgt_ok)
                    st = trqs_pkg::STATUS_INVALID;
                else if (slots[tgt] == SLOT_RUNNING)
                    st = trqs_pkg::STATUS_BAD;
                else if (slots[tgt] != SLOT_READY || locate(tgt) < 0)
                    st = trqs_pkg::STATUS_NOT_READY;
                else
                begin
                    ready_list.delete(locate(tgt));
                    slots[tgt] = SLOT_FREE;
                    res = tgt;
                end
            end
            trqs_pkg::CMD_YIELD:
            begin
                if (!run_flag)
                    st = trqs_pkg::STATUS_NONE_RUNNING;
                else if (ready_list.size() == 0)
                    res = run_id;
                else
                begin
                    head = ready_list.pop_front();
                    slots[run_id] = SLOT_READY;
                    ready_list.push_back(run_id);
                    dispatch(head);
                    res = head;
                end
            end
            trqs_pkg::CMD_YIELD_TO:
            begin
                idx = locate(tgt);
                if (!tgt_ok)
                    st = trqs_pkg::STATUS_INVALID;
                else if (slots[tgt] == SLOT_RUNNING)
                    res = tgt;
                else if (slots[tgt] != SLOT_READY)
                    st = trqs_pkg::STATUS_BAD;
                else if (!run_flag)
                    st = trqs_pkg::STATUS_NONE_RUNNING;
                else if (idx < 0)
                    st = trqs_pkg::STATUS_NOT_READY;
                else
                begin
                    ready_list.delete(idx);
                    slots[run_id] = SLOT_READY;
                    ready_list.push_back(run_id);
                    dispatch(tgt);
                    res = tgt;
                end
            end
            default:
            begin
                if (run_flag)
                    res = run_id;
                else
                    st = trqs_pkg::STATUS_NONE_RUNNING;
            end
        endcase
        r.status         = st;
        r.result_thread  = trqs_pkg::RESULT_W'(res);
        r.running_thread = run_flag ? trqs_pkg::RESULT_W'(run_id) : '0;
        r.running_valid  = run_flag;
        replies_due.push_back(r);
    endfunction

    function void report(string field, int unsigned want, int unsigned got, longint stamp);
        failures++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", stamp, field, want, got);
    endfunction

    function void check_reply(sched_reply_t got, longint stamp);
        sched_reply_t want;
        if (replies_due.size() == 0)
        begin
            failures++;
            $display("%0t: unexpected transfer, expected none, actual %p", stamp, got);
            return;
        end
        want = replies_due.pop_front();
        if (got.status !== want.status)
            report("status", want.status, got.status, stamp);
        if (got.result_thread !== want.result_thread)
            report("result_thread", want.result_thread, got.result_thread, stamp);
        if (got.running_thread !== want.running_thread)
            report("running_thread", want.running_thread, got.running_thread, stamp);
        if (got.running_valid !== want.running_valid)
            report("running_valid", want.running_valid, got.running_valid, stamp);
    endfunction
endclass

module tb_thread_ready_queue_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                         RANDOM_ITEMS  = 2000;
    localparam int                         STALL_LIMIT   = 4000;
    localparam int                         SETTLE_CYCLES = 50;
    localparam logic [trqs_pkg::CMD_W-1:0] CMD_SPARE_LO  = 3'd6;
    localparam logic [trqs_pkg::CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

    typedef enum {MIX_FILL, MIX_BALANCE, MIX_DRAIN} mix_t;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          cmd_valid     = 1'b0;
    logic [trqs_pkg::CMD_W-1:0]    cmd_code      = trqs_pkg::CMD_QUERY;
    logic [trqs_pkg::TARGET_W-1:0] cmd_target    = '0;
    logic                          sink_ready    = 1'b0;
    logic                          calm          = 1'b0;
    int unsigned                   quiet_cycles  = 0;
    sched_reply_t                  seen;
    sched_scoreboard               sb            = new();
    mix_t                          mix;
    int                            n;

    trqs_cmd_if cmd_if();
    trqs_rsp_if rsp_if();

    assign cmd_if.valid         = cmd_valid;
    assign cmd_if.command       = cmd_code;
    assign cmd_if.target_thread = cmd_target;
    assign rsp_if.ready         = sink_ready;

    thread_ready_queue_scheduler u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        sink_ready <= calm || ($urandom_range(0, 99) >= 17);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_if.valid && cmd_if.ready)
                sb.note_command(cmd_if.command, cmd_if.target_thread);
            if (rsp_if.valid && rsp_if.ready)
            begin
                seen = {rsp_if.status, rsp_if.result_thread,
                        rsp_if.running_thread, rsp_if.running_valid};
                sb.check_reply(seen, $time);
            end
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Enter and leave at a falling edge; hold the command until transferred.
    task automatic send_command(logic [trqs_pkg::CMD_W-1:0] code,
                                logic [trqs_pkg::TARGET_W-1:0] target, bit no_gap);
        while (!no_gap && $urandom_range(0, 99) < 17)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid  <= 1'b1;
        cmd_code   <= code;
        cmd_target <= target;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_for_replies();
        cmd_valid <= 1'b0;
        @(negedge clk);
        while (sb.replies_due.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [trqs_pkg::CMD_W-1:0] pick_command(mix_t m);
        int                         weights[7];
        logic [trqs_pkg::CMD_W-1:0] codes[6];
        int                         roll;
        int                         i;
        codes = '{trqs_pkg::CMD_CREATE, trqs_pkg::CMD_EXIT, trqs_pkg::CMD_KILL,
                  trqs_pkg::CMD_YIELD, trqs_pkg::CMD_YIELD_TO, trqs_pkg::CMD_QUERY};
        case (m)
            MIX_FILL:    weights = '{55, 8, 10, 10, 10, 5, 2};
            MIX_BALANCE: weights = '{25, 15, 18, 15, 17, 7, 3};
            default:     weights = '{8, 30, 30, 10, 15, 5, 2};
        endcase
        roll = $urandom_range(0, 99);
        for (i = 0; i < 6; i++)
        begin
            if (roll < weights[i])
                return codes[i];
            roll -= weights[i];
        end
        return $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    endfunction

    function automatic logic [trqs_pkg::TARGET_W-1:0] pick_target();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35 && sb.ready_list.size() != 0)
            return trqs_pkg::TARGET_W'(
                sb.ready_list[$urandom_range(0, sb.ready_list.size() - 1)]);
        if (roll < 45)
            return trqs_pkg::TARGET_W'(sb.run_id);
        if (roll < 85)
            return trqs_pkg::TARGET_W'($urandom_range(0, trqs_pkg::THREAD_SLOTS - 1));
        return trqs_pkg::TARGET_W'($urandom_range(0, 255));
    endfunction

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_command(trqs_pkg::CMD_QUERY, 8'd0, 1'b0);
        send_command(trqs_pkg::CMD_YIELD, 8'd0, 1'b0);
        send_command(trqs_pkg::CMD_YIELD_TO, 8'd0, 1'b0);
        send_command(trqs_pkg::CMD_YIELD_TO, 8'd255, 1'b0);
        send_command(trqs_pkg::CMD_YIELD_TO, 8'd7, 1'b0);
        send_command(trqs_pkg::CMD_KILL, 8'd0, 1'b0);
        send_command(trqs_pkg::CMD_KILL, 8'd31, 1'b0);
        send_command(trqs_pkg::CMD_KILL, 8'd32, 1'b0);
        send_command(trqs_pkg::CMD_EXIT, 8'd0, 1'b0);
        send_command(trqs_pkg::CMD_EXIT, 8'd0, 1'b0);
        send_command(trqs_pkg::CMD_YIELD, 8'd0, 1'b0);
        send_command(trqs_pkg::CMD_QUERY, 8'd0, 1'b0);
        send_command(trqs_pkg::CMD_CREATE, 8'd0, 1'b0);
        send_command(trqs_pkg::CMD_CREATE, 8'd0, 1'b0);
        send_command(trqs_pkg::CMD_YIELD_TO, 8'd1, 1'b0);
        send_command(trqs_pkg::CMD_EXIT, 8'd0, 1'b0);
        send_command(trqs_pkg::CMD_CREATE, 8'd0, 1'b0);
        send_command(trqs_pkg::CMD_CREATE, 8'd0, 1'b0);
        send_command(trqs_pkg::CMD_CREATE, 8'd0, 1'b0);
        send_command(trqs_pkg::CMD_KILL, 8'd3, 1'b0);
        send_command(trqs_pkg::CMD_KILL, 8'd4, 1'b0);
        send_command(trqs_pkg::CMD_KILL, 8'd1, 1'b0);
        send_command(trqs_pkg::CMD_CREATE, 8'd0, 1'b0);
        send_command(trqs_pkg::CMD_YIELD, 8'd0, 1'b0);
        send_command(trqs_pkg::CMD_YIELD_TO, 8'd0, 1'b0);
        send_command(CMD_SPARE_LO, 8'd0, 1'b0);
        send_command(CMD_SPARE_HI, 8'hff, 1'b0);
        wait_for_replies();

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 96 == 0)
                mix = mix_t'($urandom_range(0, 2));
            calm <= (n >= 800 && n < 1100);
            if (n == 1500)
                wait_for_replies();
            send_command(pick_command(mix), pick_target(), n >= 800 && n < 1100);
        end

        wait_for_replies();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.failures == 0 && sb.replies_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
